// ----- rtl/core/ppbc_pkg.sv -----
`timescale 1ns / 1ps
// Types, codes and constants shared by the pulse period band classifier.
package ppbc_pkg;

  localparam int unsigned CapW    = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned RegIdxW = 2;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned PdataW  = 32;

  localparam logic [CapW-1:0] RollSplit = 16'h8000;

  localparam logic [CapW-1:0] BandAMinRst = 16'd1364;
  localparam logic [CapW-1:0] BandAMaxRst = 16'd1666;
  localparam logic [CapW-1:0] BandBMinRst = 16'd5000;
  localparam logic [CapW-1:0] BandBMaxRst = 16'd6250;

  localparam logic [RegIdxW-1:0] RegBandAMin = 2'd0;
  localparam logic [RegIdxW-1:0] RegBandAMax = 2'd1;
  localparam logic [RegIdxW-1:0] RegBandBMin = 2'd2;
  localparam logic [RegIdxW-1:0] RegBandBMax = 2'd3;

  typedef enum logic [1:0] {
    KIND_CAPTURE = 2'd0,
    KIND_ROLL    = 2'd1,
    KIND_START   = 2'd2,
    KIND_GIVE_UP = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ID_UNKNOWN = 2'd0,
    ID_BAND_A  = 2'd1,
    ID_BAND_B  = 2'd2
  } ident_e;

  typedef enum logic {
    MODE_IDENTIFY = 1'b0,
    MODE_KNOWN    = 1'b1
  } mode_e;

  typedef struct packed {
    logic [CapW-1:0] a_min;
    logic [CapW-1:0] a_max;
    logic [CapW-1:0] b_min;
    logic [CapW-1:0] b_max;
  } band_cfg_t;

  typedef struct packed {
    kind_e           kind;
    logic [CapW-1:0] capture_time;
    logic            rollover_pending;
    mode_e           search_mode;
  } in_item_t;

  typedef struct packed {
    logic             found;
    ident_e           identity;
    logic [TimeW-1:0] period;
    logic             period_valid;
    logic             searching;
  } out_item_t;

  function automatic logic in_band(logic [TimeW-1:0] p, logic [CapW-1:0] lo,
                                   logic [CapW-1:0] hi);
    logic [TimeW-1:0] lo_x;
    logic [TimeW-1:0] hi_x;
    lo_x = {{(TimeW-CapW){1'b0}}, lo};
    hi_x = {{(TimeW-CapW){1'b0}}, hi};
    return (p > lo_x) && (p < hi_x);
  endfunction

endpackage

// ----- rtl/core/ppbc_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
interface ppbc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] capture_time;
  logic        rollover_pending;
  logic        search_mode;

  modport source (output valid, kind, capture_time, rollover_pending, search_mode,
                  input ready);
  modport sink (input valid, kind, capture_time, rollover_pending, search_mode,
                output ready);
endinterface

interface ppbc_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  identity;
  logic [31:0] period;
  logic        period_valid;
  logic        searching;

  modport source (output valid, found, identity, period, period_valid, searching,
                  input ready);
  modport sink (input valid, found, identity, period, period_valid, searching,
                output ready);
endinterface

// ----- rtl/core/ppbc_regs.sv -----
`timescale 1ns / 1ps
// APB register file holding the bounds of the two period bands.
module ppbc_regs
  import ppbc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output band_cfg_t         cfg_o
);

  band_cfg_t          cfg_q;
  logic               wr_en;
  logic [RegIdxW-1:0] idx;
  logic [CapW-1:0]    rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[PaddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_min <= BandAMinRst;
      cfg_q.a_max <= BandAMaxRst;
      cfg_q.b_min <= BandBMinRst;
      cfg_q.b_max <= BandBMaxRst;
    end else if (wr_en) begin
      unique case (idx)
        RegBandAMin: cfg_q.a_min <= pwdata[CapW-1:0];
        RegBandAMax: cfg_q.a_max <= pwdata[CapW-1:0];
        RegBandBMin: cfg_q.b_min <= pwdata[CapW-1:0];
        RegBandBMax: cfg_q.b_max <= pwdata[CapW-1:0];
        default:     cfg_q       <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegBandAMin: rd_val = cfg_q.a_min;
      RegBandAMax: rd_val = cfg_q.a_max;
      RegBandBMin: rd_val = cfg_q.b_min;
      RegBandBMax: rd_val = cfg_q.b_max;
      default:     rd_val = '0;
    endcase
  end

  assign prdata = {{(PdataW-CapW){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

endmodule

// ----- rtl/core/pulse_period_band_classifier_core.sv -----
`timescale 1ns / 1ps
// Pulse period band classifier: capture timing, band search and result channel.
//
// Takes one item per cycle: edge captures, timer rollover ticks, search starts
// and give-ups. Each accepted item yields exactly one result, passing through the
// input register and then the result register; the rate is set by the single
// state-update step between them, a 32-bit period subtract and four bound
// compares. Input stalls only when the result register is full and not taken.
// Band bounds are written over APB at byte addresses 0, 4, 8, 12 (band A min,
// band A max, band B min, band B max; all exclusive) and must change only while
// the block is idle.
module pulse_period_band_classifier_core
  import ppbc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  ppbc_in_if.sink           item_i,
  ppbc_out_if.source        result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  band_cfg_t cfg;

  ppbc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  logic      inq_valid_q;
  in_item_t  inq_q;
  logic      advance;
  logic      in_xfer;

  // result register
  logic      res_valid_q;
  out_item_t res_q;
  out_item_t res_d;

  // block state
  logic             searching_q, searching_d;
  logic             first_q, first_d;
  logic             found_latch_q, found_latch_d;
  logic [TimeW-1:0] last_q, last_d;
  logic [CapW-1:0]  roll_q, roll_d;
  mode_e            mode_q, mode_d;
  ident_e           ident_q, ident_d;

  logic             found;
  logic             pvalid;
  logic [TimeW-1:0] period;
  logic [CapW-1:0]  roll_c;
  logic [TimeW-1:0] t_ext;
  logic             arm;

  assign advance      = inq_valid_q && (!res_valid_q || result_o.ready);
  assign item_i.ready = !inq_valid_q || advance;
  assign in_xfer      = item_i.valid && item_i.ready;

  always_comb begin
    searching_d   = searching_q;
    first_d       = first_q;
    found_latch_d = searching_q ? found_latch_q : 1'b0;
    last_d        = last_q;
    roll_d        = roll_q;
    mode_d        = mode_q;
    ident_d       = ident_q;
    found         = 1'b0;
    pvalid        = 1'b0;
    period        = '0;
    arm           = 1'b0;
    roll_c        = roll_q + CapW'(inq_q.rollover_pending &&
                                   (inq_q.capture_time < RollSplit));
    t_ext         = {roll_c, inq_q.capture_time};

    unique case (inq_q.kind)
      KIND_ROLL: roll_d = roll_q + 1'b1;
      KIND_CAPTURE: begin
        if (searching_q) begin
          roll_d = roll_c;
          if (first_q) begin
            first_d = 1'b0;
          end else begin
            period = t_ext - last_q;
            pvalid = 1'b1;
            if (!found_latch_d) begin
              if (mode_q == MODE_IDENTIFY) begin
                if (in_band(period, cfg.a_min, cfg.a_max)) begin
                  ident_d = ID_BAND_A;
                  found   = 1'b1;
                end else if (in_band(period, cfg.b_min, cfg.b_max)) begin
                  ident_d = ID_BAND_B;
                  found   = 1'b1;
                end
              end else if (ident_q == ID_BAND_A) begin
                found = in_band(period, cfg.a_min, cfg.a_max);
              end else if (ident_q == ID_BAND_B) begin
                found = in_band(period, cfg.b_min, cfg.b_max);
              end
            end
          end
          last_d = t_ext;
          if (found) begin
            searching_d   = 1'b0;
            first_d       = 1'b1;
            found_latch_d = 1'b0;
          end
        end
      end
      KIND_START: begin
        if (!searching_q) begin
          mode_d = inq_q.search_mode;
          if (inq_q.search_mode == MODE_IDENTIFY) begin
            ident_d = ID_UNKNOWN;
            arm     = 1'b1;
          end else begin
            arm = (ident_q == ID_BAND_A) || (ident_q == ID_BAND_B);
          end
          if (arm) begin
            found_latch_d = 1'b0;
            first_d       = 1'b1;
            searching_d   = 1'b1;
          end
        end
      end
      KIND_GIVE_UP: begin
        if (searching_q) begin
          searching_d   = 1'b0;
          first_d       = 1'b1;
          found_latch_d = 1'b0;
        end
      end
      default: begin
        searching_d = searching_q;
      end
    endcase

    res_d.found        = found;
    res_d.identity     = ident_d;
    res_d.period       = period;
    res_d.period_valid = pvalid;
    res_d.searching    = searching_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q   <= 1'b0;
      res_valid_q   <= 1'b0;
      searching_q   <= 1'b0;
      first_q       <= 1'b1;
      found_latch_q <= 1'b0;
      last_q        <= '0;
      roll_q        <= '0;
      mode_q        <= MODE_IDENTIFY;
      ident_q       <= ID_UNKNOWN;
    end else begin
      if (item_i.ready) begin
        inq_valid_q <= item_i.valid;
      end
      if (advance) begin
        res_valid_q   <= 1'b1;
        searching_q   <= searching_d;
        first_q       <= first_d;
        found_latch_q <= found_latch_d;
        last_q        <= last_d;
        roll_q        <= roll_d;
        mode_q        <= mode_d;
        ident_q       <= ident_d;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      inq_q.kind             <= kind_e'(item_i.kind);
      inq_q.capture_time     <= item_i.capture_time;
      inq_q.rollover_pending <= item_i.rollover_pending;
      inq_q.search_mode      <= mode_e'(item_i.search_mode);
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.found        = res_q.found;
  assign result_o.identity     = res_q.identity;
  assign result_o.period       = res_q.period;
  assign result_o.period_valid = res_q.period_valid;
  assign result_o.searching    = res_q.searching;

`ifndef SYNTHESIS
  a_found_ends_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.found |-> !result_o.searching && result_o.period_valid)
    else $error("found result with search still armed or no period");

  a_known_has_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    searching_q && (mode_q == MODE_KNOWN) |-> (ident_q != ID_UNKNOWN))
    else $error("known-band search armed without identity");

  a_latch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_latch_q)
    else $error("found latch left set after an item");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !result_o.ready |=> res_valid_q && $stable(res_q))
    else $error("stalled result changed");
`endif

endmodule
